/* design/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int MEM_BYTES_DEF    = 4096;
  localparam int MAX_SEGMENTS_DEF = 16;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 12;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

endpackage

/* design/ffsa_if.sv */
// ----------------------------------------------------------------------------
// ffsa_req_if / ffsa_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
  logic                      valid;
  logic                      ready;
  logic [ffsa_pkg::OP_W-1:0]   op;
  logic [ffsa_pkg::SIZE_W-1:0] size;
  logic [ffsa_pkg::ADDR_W-1:0] address;
  modport source (output valid, op, size, address, input ready);
  modport sink   (input valid, op, size, address, output ready);
endinterface

interface ffsa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ffsa_pkg::STAT_W-1:0] status;
  logic [ffsa_pkg::SIZE_W-1:0] start_address;
  logic [ffsa_pkg::ADDR_W-1:0] old_address;
  logic                      last;
  modport source (output valid, status, start_address, old_address, last, input ready);
  modport sink   (input valid, status, start_address, old_address, last, output ready);
endinterface

/* design/first_fit_segment_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit segment allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request at a time; in_req is ready only in idle while the result register
// is free or being taken. Allocate and free walk the table one entry per cycle
// through a shared compare unit; a split then shifts the tail up one entry per
// cycle. Defragment walks every entry once, emitting one result per used segment
// and waiting while the result is held, then clears the unused tail one entry
// per cycle.
module first_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ffsa_req_if.sink   in_req,
  ffsa_rsp_if.source out_rsp
);
  localparam int MEM_BYTES = ffsa_pkg::MEM_BYTES_DEF;
  localparam int SW = ffsa_pkg::SIZE_W;
  localparam int AW = ffsa_pkg::ADDR_W;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int PW = $clog2(MEM_BYTES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [PW-1:0] MEM_P   = PW'(MEM_BYTES);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_SPLIT  = 7'b0001000,
    S_DFRAG  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t                   state_r;
  logic [AW-1:0]            st_r   [MAX_SEGMENTS];
  logic [SW-1:0]            sz_r   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0]  used_r;
  logic [CW-1:0]            cnt_r;
  logic [IW-1:0]            idx_r, tgt_r, wr_r;
  logic                     wrdone_r;
  logic [PW-1:0]            pos_r;
  logic [ffsa_pkg::OP_W-1:0] op_r;
  logic [SW-1:0]            req_r;
  logic [AW-1:0]            adr_r;
  logic                     ov_r, olast_r;
  logic [ffsa_pkg::STAT_W-1:0] ost_r;
  logic [SW-1:0]            osa_r;
  logic [AW-1:0]            ooa_r;

  logic fit, exact, hit, out_free, at_end, last_ent, load_out;
  logic [CW-1:0] idx_ext;

  assign out_free = !ov_r || out_rsp.ready;
  assign idx_ext  = CW'(idx_r);
  assign at_end   = (idx_ext >= cnt_r);
  assign last_ent = ((idx_ext + CW'(1)) >= cnt_r);
  assign load_out = out_free && ((state_r == S_RESP) ||
                    ((state_r == S_DFRAG) && (at_end || used_r[idx_r])));

  ffsa_cmp #(.SW(SW), .AW(AW)) u_cmp (
    .used     (used_r[idx_r]),
    .seg_size (sz_r[idx_r]),
    .seg_start(st_r[idx_r]),
    .req_size (req_r),
    .req_addr (adr_r),
    .fit      (fit),
    .exact    (exact),
    .hit      (hit)
  );

  assign in_req.ready          = (state_r == S_IDLE) && out_free;
  assign out_rsp.valid         = ov_r;
  assign out_rsp.status        = ost_r;
  assign out_rsp.start_address = osa_r;
  assign out_rsp.old_address   = ooa_r;
  assign out_rsp.last          = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_rsp.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= CW'(1);
      used_r   <= '0;
      st_r[0]  <= '0;
      sz_r[0]  <= SW'(MEM_BYTES);
      for (int k = 1; k < MAX_SEGMENTS; k++) begin
        st_r[k] <= '0;
        sz_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid && out_free) begin
            op_r  <= in_req.op;
            req_r <= in_req.size;
            adr_r <= in_req.address;
            idx_r <= '0;
            wr_r  <= '0;
            wrdone_r <= 1'b0;
            pos_r <= '0;
            unique case (ffsa_pkg::op_t'(in_req.op))
              ffsa_pkg::OP_ALLOC: begin
                if (in_req.size == '0) begin
                  ost_r <= ffsa_pkg::ST_BAD;
                  state_r <= S_RESP;
                end else state_r <= S_SCAN;
              end
              ffsa_pkg::OP_FREE:   state_r <= S_SCAN;
              ffsa_pkg::OP_DEFRAG: state_r <= S_DFRAG;
              default: begin
                ost_r <= ffsa_pkg::ST_BAD;
                state_r <= S_RESP;
              end
            endcase
            osa_r <= '0;
            ooa_r <= '0;
            olast_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (at_end) begin
            ost_r <= (ffsa_pkg::op_t'(op_r) == ffsa_pkg::OP_ALLOC) ?
                     ffsa_pkg::ST_NOFIT : ffsa_pkg::ST_BAD;
            state_r <= S_RESP;
          end else if (ffsa_pkg::op_t'(op_r) == ffsa_pkg::OP_FREE) begin
            if (hit) begin
              used_r[idx_r] <= 1'b0;
              ost_r <= ffsa_pkg::ST_OK;
              osa_r <= SW'(adr_r);
              state_r <= S_RESP;
            end else if (last_ent) begin
              ost_r <= ffsa_pkg::ST_BAD;
              state_r <= S_RESP;
            end else idx_r <= idx_r + 1'b1;
          end else if (fit) begin
            if (exact) begin
              used_r[idx_r] <= 1'b1;
              ost_r <= ffsa_pkg::ST_OK;
              osa_r <= SW'(st_r[idx_r]);
              state_r <= S_RESP;
            end else if (cnt_r >= CNT_MAX) begin
              ost_r <= ffsa_pkg::ST_FULL;
              state_r <= S_RESP;
            end else begin
              tgt_r <= idx_r;
              idx_r <= IW'(cnt_r);
              state_r <= S_SHIFT;
            end
          end else if (last_ent) begin
            ost_r <= ffsa_pkg::ST_NOFIT;
            state_r <= S_RESP;
          end else idx_r <= idx_r + 1'b1;
        end
        S_SHIFT: begin
          if (idx_r == tgt_r + 1'b1) state_r <= S_SPLIT;
          else begin
            st_r[idx_r]   <= st_r[idx_r - 1'b1];
            sz_r[idx_r]   <= sz_r[idx_r - 1'b1];
            used_r[idx_r] <= used_r[idx_r - 1'b1];
            idx_r <= idx_r - 1'b1;
          end
        end
        S_SPLIT: begin
          st_r[idx_r]   <= st_r[tgt_r] + AW'(req_r);
          sz_r[idx_r]   <= sz_r[tgt_r] - req_r;
          used_r[idx_r] <= 1'b0;
          sz_r[tgt_r]   <= req_r;
          used_r[tgt_r] <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
          ost_r <= ffsa_pkg::ST_OK;
          osa_r <= SW'(st_r[tgt_r]);
          state_r <= S_RESP;
        end
        S_DFRAG: begin
          if (out_free) begin
            if (at_end) begin
              ost_r <= ffsa_pkg::ST_OK;
              ooa_r <= '0;
              olast_r <= 1'b1;
              if (pos_r < MEM_P && !wrdone_r) begin
                st_r[wr_r]   <= AW'(pos_r);
                sz_r[wr_r]   <= SW'(MEM_P - pos_r);
                used_r[wr_r] <= 1'b0;
                osa_r <= SW'(pos_r);
                cnt_r <= CW'(wr_r) + 1'b1;
                wrdone_r <= (wr_r == IW'(MAX_SEGMENTS - 1));
                idx_r <= wr_r + 1'b1;
              end else begin
                osa_r <= SW'(MEM_BYTES);
                cnt_r <= wrdone_r ? CNT_MAX : CW'(wr_r);
                wrdone_r <= wrdone_r;
                idx_r <= wr_r;
              end
              state_r <= S_CLEAR;
            end else begin
              if (used_r[idx_r]) begin
                ost_r <= ffsa_pkg::ST_OK;
                osa_r <= SW'(pos_r);
                ooa_r <= st_r[idx_r];
                olast_r <= 1'b0;
                st_r[wr_r]   <= AW'(pos_r);
                sz_r[wr_r]   <= sz_r[idx_r];
                used_r[wr_r] <= 1'b1;
                pos_r <= pos_r + PW'(sz_r[idx_r]);
                if (wr_r == IW'(MAX_SEGMENTS - 1)) wrdone_r <= 1'b1;
                else wr_r <= wr_r + 1'b1;
              end
              idx_r <= idx_r + 1'b1;
              if (idx_r == IW'(MAX_SEGMENTS - 1)) cnt_r <= '0;
            end
          end
        end
        S_CLEAR: begin
          if (wrdone_r || (CW'(idx_r) >= CNT_MAX) ||
              (idx_r == '0 && cnt_r != '0)) state_r <= S_IDLE;
          else begin
            st_r[idx_r] <= '0;
            sz_r[idx_r] <= '0;
            used_r[idx_r] <= 1'b0;
            if (idx_r == IW'(MAX_SEGMENTS - 1)) state_r <= S_IDLE;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_RESP: begin
          if (out_free) begin
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A pending result must hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_rsp.ready |=> ov_r && $stable(osa_r))
    else $error("result dropped under stall");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("segment count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_req.ready) else $error("ready while busy");
endmodule

/* design/ffsa_cmp.sv */
// ----------------------------------------------------------------------------
// ffsa_cmp
// Shared segment compare unit: fit test, exact test and address match.
// ----------------------------------------------------------------------------
module ffsa_cmp #(
  parameter int SW = 13,
  parameter int AW = 12
) (
  input  logic          used,
  input  logic [SW-1:0] seg_size,
  input  logic [AW-1:0] seg_start,
  input  logic [SW-1:0] req_size,
  input  logic [AW-1:0] req_addr,
  output logic          fit,
  output logic          exact,
  output logic          hit
);
  assign fit   = !used && (seg_size >= req_size);
  assign exact = (seg_size == req_size);
  assign hit   = (seg_start == req_addr);
endmodule

/* sim/tb_ffsa_if.sv */
// ----------------------------------------------------------------------------
// tb_ffsa_if
// Holds the timeout limit used by the allocator testbench.
// The channel interfaces themselves are compiled from the design folder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_ffsa_chan_pkg;
  localparam int REQ_TIMEOUT_CYCLES = 400000;
endpackage

/* sim/tb_first_fit_segment_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_segment_allocator_core
// Drives allocate, free and defragment requests into the allocator, keeps a
// shadow segment table that predicts every result, and compares each result
// field by field, under random idling on both channels and long stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator_core;

  localparam int MEMB = ffsa_pkg::MEM_BYTES_DEF;
  localparam int NSEG = ffsa_pkg::MAX_SEGMENTS_DEF;

  typedef struct packed {
    logic [ffsa_pkg::OP_W-1:0]   op;
    logic [ffsa_pkg::SIZE_W-1:0] size;
    logic [ffsa_pkg::ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic [ffsa_pkg::STAT_W-1:0] status;
    logic [ffsa_pkg::SIZE_W-1:0] start_address;
    logic [ffsa_pkg::ADDR_W-1:0] old_address;
    logic                        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ffsa_req_if in_req();
  ffsa_rsp_if out_rsp();

  first_fit_segment_allocator_core uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       tbl_start[NSEG];
  int       tbl_size[NSEG];
  bit       tbl_used[NSEG];
  int       tbl_count;
  int       send_idle_pct = 16;
  int       recv_idle_pct = 56;
  int       hold_off = 0;
  bit       all_queued = 1'b0;
  int       errors = 0;
  longint   cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_result(int st, int sa, int oa, bit lst);
    result_t r;
    r.status        = st[ffsa_pkg::STAT_W-1:0];
    r.start_address = sa[ffsa_pkg::SIZE_W-1:0];
    r.old_address   = oa[ffsa_pkg::ADDR_W-1:0];
    r.last          = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NSEG; i++) begin
      tbl_start[i] = 0;
      tbl_size[i]  = 0;
      tbl_used[i]  = 1'b0;
    end
    tbl_size[0] = MEMB;
    tbl_count   = 1;
  endfunction

  function automatic void predict_allocation(request_t rq);
    int req;
    int i;
    req = rq.size;
    if (rq.op == ffsa_pkg::OP_ALLOC) begin
      if (req == 0) begin
        push_result(ffsa_pkg::ST_BAD, 0, 0, 1);
        return;
      end
      for (i = 0; i < tbl_count; i++)
        if (!tbl_used[i] && tbl_size[i] >= req) break;
      if (i >= tbl_count) begin
        push_result(ffsa_pkg::ST_NOFIT, 0, 0, 1);
      end else if (tbl_size[i] == req) begin
        tbl_used[i] = 1'b1;
        push_result(ffsa_pkg::ST_OK, tbl_start[i], 0, 1);
      end else if (tbl_count >= NSEG) begin
        push_result(ffsa_pkg::ST_FULL, 0, 0, 1);
      end else begin
        for (int j = tbl_count; j > i + 1; j--) begin
          tbl_start[j] = tbl_start[j-1];
          tbl_size[j]  = tbl_size[j-1];
          tbl_used[j]  = tbl_used[j-1];
        end
        tbl_start[i+1] = tbl_start[i] + req;
        tbl_size[i+1]  = tbl_size[i] - req;
        tbl_used[i+1]  = 1'b0;
        tbl_size[i]    = req;
        tbl_used[i]    = 1'b1;
        tbl_count++;
        push_result(ffsa_pkg::ST_OK, tbl_start[i], 0, 1);
      end
    end else if (rq.op == ffsa_pkg::OP_FREE) begin
      for (i = 0; i < tbl_count; i++)
        if (tbl_start[i] == int'(rq.address)) break;
      if (i < tbl_count) begin
        tbl_used[i] = 1'b0;
        push_result(ffsa_pkg::ST_OK, rq.address, 0, 1);
      end else begin
        push_result(ffsa_pkg::ST_BAD, 0, 0, 1);
      end
    end else if (rq.op == ffsa_pkg::OP_DEFRAG) begin
      int w;
      int pos;
      w = 0;
      pos = 0;
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_used[i]) begin
          push_result(ffsa_pkg::ST_OK, pos, tbl_start[i], 0);
          tbl_start[w] = pos;
          tbl_size[w]  = tbl_size[i];
          tbl_used[w]  = 1'b1;
          pos += tbl_size[i];
          w++;
        end
      end
      if (pos < MEMB && w < NSEG) begin
        tbl_start[w] = pos;
        tbl_size[w]  = MEMB - pos;
        tbl_used[w]  = 1'b0;
        w++;
        push_result(ffsa_pkg::ST_OK, pos, 0, 1);
      end else begin
        push_result(ffsa_pkg::ST_OK, MEMB, 0, 1);
      end
      for (i = w; i < NSEG; i++) begin
        tbl_start[i] = 0;
        tbl_size[i]  = 0;
        tbl_used[i]  = 1'b0;
      end
      tbl_count = w;
    end else begin
      push_result(ffsa_pkg::ST_BAD, 0, 0, 1);
    end
  endfunction

  function automatic request_t make_req(ffsa_pkg::op_t op, int size, int address);
    request_t rq;
    rq.op      = op;
    rq.size    = size[ffsa_pkg::SIZE_W-1:0];
    rq.address = address[ffsa_pkg::ADDR_W-1:0];
    return rq;
  endfunction

  function automatic int live_address();
    int k;
    if (tbl_count == 0) return 0;
    k = $urandom_range(tbl_count - 1);
    return tbl_start[k];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid   <= 1'b0;
      in_req.op      <= ffsa_pkg::OP_ALLOC;
      in_req.size    <= '0;
      in_req.address <= '0;
    end else if (!in_req.valid || in_req.ready) begin
      if (in_req.valid) predict_allocation(request_t'({in_req.op, in_req.size, in_req.address}));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        in_req.valid   <= 1'b1;
        in_req.op      <= rq.op;
        in_req.size    <= rq.size;
        in_req.address <= rq.address;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d start=%0d", out_rsp.status, out_rsp.start_address);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (out_rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_rsp.status);
            errors++;
          end
          if (out_rsp.start_address !== e.start_address) begin
            $error("start_address: expected %0d, got %0d", e.start_address,
                   out_rsp.start_address);
            errors++;
          end
          if (out_rsp.old_address !== e.old_address) begin
            $error("old_address: expected %0d, got %0d", e.old_address, out_rsp.old_address);
            errors++;
          end
          if (out_rsp.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_rsp.last);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_req.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
        int sz;
        case ($urandom_range(9))
          0:       sz = $urandom_range(8191);
          1:       sz = $urandom_range(4096, 2048);
          default: sz = $urandom_range(600, 1);
        endcase
        pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, sz, 0));
      end else if (pick < 80) begin
        // mostly addresses of live segments
        if ($urandom_range(3) != 0)
          pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, $urandom, live_address()));
        else
          pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, $urandom, $urandom_range(4095)));
      end else if (pick < 95) begin
        pending_reqs.push_back(make_req(ffsa_pkg::OP_DEFRAG, $urandom, $urandom));
      end else begin
        pending_reqs.push_back(make_req(ffsa_pkg::OP_RSVD, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    table_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 8191, 4095));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 4097, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 100, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 200, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, 0, 100));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, 0, 100));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, 0, 4095));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 200, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_RSVD, 8191, 4095));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_DEFRAG, 0, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 3896, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_DEFRAG, 0, 0));
    for (int k = 0; k < 3; k++)
      pending_reqs.push_back(make_req(ffsa_pkg::OP_FREE, 0, 100 * k));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_DEFRAG, 0, 0));
    for (int k = 0; k < 17; k++) pending_reqs.push_back(make_req(ffsa_pkg::OP_ALLOC, 1, 0));
    pending_reqs.push_back(make_req(ffsa_pkg::OP_DEFRAG, 0, 0));
    drain();
    // random phases with swapped idling, then a phase with no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 16 : 0;
      if (ph == 1) hold_off = 300;
      queue_random(40);
      drain();
    end
    all_queued = 1'b1;
  end

  initial begin
    wait (all_queued);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (cycles > tb_ffsa_chan_pkg::REQ_TIMEOUT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
